// ----- hw/rtl/sst_pkg.sv -----
`default_nettype none

package sst_pkg;

  localparam int FIELD_BITS = 24;
  localparam int KIND_BITS  = 6;

  localparam logic [KIND_BITS-1:0] K_END     = 6'd0;
  localparam logic [KIND_BITS-1:0] K_IDENT   = 6'd1;
  localparam logic [KIND_BITS-1:0] K_BOOL    = 6'd2;
  localparam logic [KIND_BITS-1:0] K_INT     = 6'd3;
  localparam logic [KIND_BITS-1:0] K_FLOAT   = 6'd4;
  localparam logic [KIND_BITS-1:0] K_DOT     = 6'd16;
  localparam logic [KIND_BITS-1:0] K_DIV     = 6'd28;
  localparam logic [KIND_BITS-1:0] K_DIV_EQ  = 6'd29;
  localparam logic [KIND_BITS-1:0] K_UNKNOWN = 6'd42;
  localparam logic [KIND_BITS-1:0] K_UNTERM  = 6'd43;

  localparam logic [3:0] BM_TRUE  = 4'd4;
  localparam logic [3:0] BM_FALSE = 4'd9;
  localparam logic [3:0] BM_NONE  = 4'd15;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] length;
    logic                  last;
  } sst_result_t;

  typedef struct packed {
    logic [1:0]  count;
    sst_result_t r0;
    sst_result_t r1;
  } sst_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return is_alpha(c) || c == "_";
  endfunction

  function automatic logic is_ident_cont(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'd32 || c == 8'd9 || c == 8'd13 || c == 8'd10 || c == 8'd12 || c == 8'd11;
  endfunction

  function automatic logic [3:0] match_next(input logic [3:0] m, input logic [7:0] c);
    logic [3:0] r;
    r = BM_NONE;
    case (m)
      4'd0: r = (c == "t") ? 4'd1 : ((c == "f") ? 4'd5 : BM_NONE);
      4'd1: if (c == "r") r = 4'd2;
      4'd2: if (c == "u") r = 4'd3;
      4'd3: if (c == "e") r = 4'd4;
      4'd5: if (c == "a") r = 4'd6;
      4'd6: if (c == "l") r = 4'd7;
      4'd7: if (c == "s") r = 4'd8;
      4'd8: if (c == "e") r = 4'd9;
      default: r = BM_NONE;
    endcase
    return r;
  endfunction

  // Operators that may take a second character: returns {found, index}.
  function automatic logic [4:0] op_lookup(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      "-": r = {1'b1, 4'd0};
      "=": r = {1'b1, 4'd1};
      "!": r = {1'b1, 4'd2};
      "+": r = {1'b1, 4'd3};
      "*": r = {1'b1, 4'd4};
      "%": r = {1'b1, 4'd5};
      "&": r = {1'b1, 4'd6};
      "|": r = {1'b1, 4'd7};
      "<": r = {1'b1, 4'd8};
      ">": r = {1'b1, 4'd9};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [KIND_BITS-1:0] op_base(input logic [3:0] idx);
    logic [KIND_BITS-1:0] r;
    case (idx)
      4'd0: r = 6'd17;
      4'd1: r = 6'd20;
      4'd2: r = 6'd22;
      4'd3: r = 6'd24;
      4'd4: r = 6'd26;
      4'd5: r = 6'd30;
      4'd6: r = 6'd32;
      4'd7: r = 6'd34;
      4'd8: r = 6'd36;
      default: r = 6'd39;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] op_second(input logic [3:0] idx, input logic [7:0] c);
    logic [1:0] r;
    case (idx)
      4'd0: r = (c == ">") ? 2'd1 : ((c == "=") ? 2'd2 : 2'd0);
      4'd8: r = (c == "<") ? 2'd1 : ((c == "=") ? 2'd2 : 2'd0);
      4'd9: r = (c == ">") ? 2'd1 : ((c == "=") ? 2'd2 : 2'd0);
      4'd6: r = (c == "&") ? 2'd1 : 2'd0;
      4'd7: r = (c == "|") ? 2'd1 : 2'd0;
      default: r = (c == "=") ? 2'd1 : 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
    logic [KIND_BITS-1:0] r;
    case (c)
      "(": r = 6'd5;
      ")": r = 6'd6;
      "{": r = 6'd7;
      "}": r = 6'd8;
      "[": r = 6'd9;
      "]": r = 6'd10;
      ",": r = 6'd11;
      ";": r = 6'd12;
      ":": r = 6'd13;
      "~": r = 6'd14;
      "^": r = 6'd15;
      default: r = K_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sst_scan.sv -----
`default_nettype none

module sst_scan #(
  parameter int OFFSET_BITS = 24,
  parameter int MAX_NEST    = 255
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        source_byte,
  input  wire logic              end_of_source,
  input  wire logic              space_ok,
  output sst_pkg::sst_push_t     push
);
  import sst_pkg::*;

  localparam int DW = $clog2(MAX_NEST + 1);

  typedef enum logic [4:0] {
    M_IDLE, M_IDENT, M_SLASH, M_LINE, M_BLOCK, M_BSLASH, M_BSTAR, M_DOT,
    M_ZERO, M_INT, M_HEX, M_FRAC, M_EXP0, M_EXPS,
    M_OP0, M_OP1, M_OP2, M_OP3, M_OP4, M_OP5, M_OP6, M_OP7, M_OP8, M_OP9
  } mode_t;

  logic                   held;
  logic [7:0]             c;
  logic                   eos;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [OFFSET_BITS-1:0] tbeg, tbeg_next;
  mode_t                  mode, mode_next;
  logic [DW-1:0]          depth, depth_next;
  logic [3:0]             bmatch, bmatch_next;

  logic                   fire;
  logic                   a_v, b_v, used, flt;
  logic [KIND_BITS-1:0]   a_k, b_k, ident_k;
  logic [OFFSET_BITS-1:0] a_s, a_l, b_s, b_l, len0, len1;
  logic [3:0]             opi;
  logic [4:0]             opl;
  logic [1:0]             off;

  assign fire     = held && space_ok;
  assign in_ready = !held || space_ok;
  assign len0     = pos - tbeg;
  assign len1     = pos + OFFSET_BITS'(1) - tbeg;
  assign opi      = 4'(mode - M_OP0);
  assign ident_k  = (bmatch == BM_TRUE || bmatch == BM_FALSE) ? K_BOOL : K_IDENT;
  assign flt      = mode == M_FRAC || mode == M_EXP0 || mode == M_EXPS;

  always_comb begin
    a_v = 1'b0; a_k = K_END; a_s = tbeg; a_l = len0;
    b_v = 1'b0; b_k = K_END; b_s = pos;  b_l = '0;
    used = 1'b0;
    off = op_second(opi, c);
    opl = op_lookup(c);
    mode_next = mode; tbeg_next = tbeg; depth_next = depth; bmatch_next = bmatch;
    pos_next = pos + OFFSET_BITS'(1);
    if (eos) begin
      a_v = 1'b1;
      unique case (mode)
        M_IDENT: a_k = ident_k;
        M_SLASH: a_k = K_DIV;
        M_BLOCK, M_BSLASH, M_BSTAR: begin
          a_k = K_UNTERM; a_s = pos; a_l = OFFSET_BITS'(1);
        end
        M_DOT: a_k = K_DOT;
        M_ZERO, M_INT, M_HEX: a_k = K_INT;
        M_FRAC, M_EXP0, M_EXPS: a_k = K_FLOAT;
        M_IDLE, M_LINE: a_v = 1'b0;
        default: a_k = op_base(opi);
      endcase
      b_v = 1'b1;
      mode_next = M_IDLE; tbeg_next = '0; depth_next = '0; bmatch_next = '0; pos_next = '0;
    end else begin
      unique case (mode)
        M_IDENT: begin
          if (is_ident_cont(c)) begin
            bmatch_next = match_next(bmatch, c); used = 1'b1;
          end else begin
            a_v = 1'b1; a_k = ident_k; mode_next = M_IDLE;
          end
        end
        M_SLASH: begin
          used = 1'b1;
          if (c == "/") mode_next = M_LINE;
          else if (c == "*") begin
            mode_next = M_BLOCK; depth_next = DW'(1);
          end else if (c == "=") begin
            a_v = 1'b1; a_k = K_DIV_EQ; a_l = len1; mode_next = M_IDLE;
          end else begin
            a_v = 1'b1; a_k = K_DIV; mode_next = M_IDLE; used = 1'b0;
          end
        end
        M_LINE: begin
          used = 1'b1;
          if (c == 8'd10) mode_next = M_IDLE;
        end
        M_BLOCK, M_BSLASH, M_BSTAR: begin
          used = 1'b1;
          if (mode == M_BSLASH && c == "*") begin
            if (depth < DW'(MAX_NEST)) depth_next = depth + DW'(1);
            mode_next = M_BLOCK;
          end else if (mode == M_BSTAR && c == "/") begin
            if (depth != '0) depth_next = depth - DW'(1);
            mode_next = (depth_next == '0) ? M_IDLE : M_BLOCK;
          end else if (c == "/") mode_next = M_BSLASH;
          else if (c == "*") mode_next = M_BSTAR;
          else mode_next = M_BLOCK;
        end
        M_DOT: begin
          if (is_digit(c)) begin
            mode_next = M_FRAC; used = 1'b1;
          end else begin
            a_v = 1'b1; a_k = K_DOT; mode_next = M_IDLE;
          end
        end
        M_HEX: begin
          used = 1'b1;
          if (!is_hex(c)) begin
            mode_next = M_IDLE; a_v = 1'b1; a_k = K_INT;
            if (c == "u" || c == "U") a_l = len1;
            else used = 1'b0;
          end
        end
        M_ZERO, M_INT, M_FRAC, M_EXP0, M_EXPS: begin
          used = 1'b1;
          if (mode == M_ZERO && (c == "x" || c == "X")) mode_next = M_HEX;
          else if (is_digit(c)) begin
            if (mode == M_ZERO) mode_next = M_INT;
            else if (mode == M_EXP0) mode_next = M_EXPS;
          end else if ((mode == M_ZERO || mode == M_INT) && c == ".") mode_next = M_FRAC;
          else if ((mode == M_ZERO || mode == M_INT || mode == M_FRAC) && (c == "e" || c == "E"))
            mode_next = M_EXP0;
          else if (mode == M_EXP0 && (c == "+" || c == "-")) mode_next = M_EXPS;
          else begin
            mode_next = M_IDLE; a_v = 1'b1; a_k = flt ? K_FLOAT : K_INT;
            if (c == "f" || c == "F" || c == "h" || c == "H") begin
              a_k = K_FLOAT; a_l = len1;
            end else if (c == "u" || c == "U") a_l = len1;
            else used = 1'b0;
          end
        end
        M_IDLE: mode_next = M_IDLE;
        default: begin
          mode_next = M_IDLE; a_v = 1'b1;
          if (off != 2'd0) begin
            a_k = op_base(opi) + KIND_BITS'(off); a_l = len1; used = 1'b1;
          end else a_k = op_base(opi);
        end
      endcase
      if (!used && !is_space(c)) begin
        tbeg_next = pos;
        if (is_ident_start(c)) begin
          mode_next = M_IDENT; bmatch_next = match_next(4'd0, c);
        end else if (c == "0") mode_next = M_ZERO;
        else if (is_digit(c)) mode_next = M_INT;
        else if (c == ".") mode_next = M_DOT;
        else if (c == "/") mode_next = M_SLASH;
        else if (opl[4]) mode_next = mode_t'(5'(M_OP0) + 5'(opl[3:0]));
        else begin
          b_v = 1'b1; b_k = single_kind(c); b_l = OFFSET_BITS'(1);
        end
      end
    end
  end

  always_comb begin
    push.count     = 2'(a_v) + 2'(b_v);
    push.r0.kind   = a_v ? a_k : b_k;
    push.r0.start  = FIELD_BITS'(a_v ? a_s : b_s);
    push.r0.length = FIELD_BITS'(a_v ? a_l : b_l);
    push.r0.last   = !(a_v && b_v);
    push.r1.kind   = b_k;
    push.r1.start  = FIELD_BITS'(b_s);
    push.r1.length = FIELD_BITS'(b_l);
    push.r1.last   = 1'b1;
    if (!fire) push.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      c   <= source_byte;
      eos <= end_of_source;
    end
    if (rst) begin
      held <= 1'b0; pos <= '0; tbeg <= '0; mode <= M_IDLE; depth <= '0; bmatch <= '0;
    end else begin
      if (in_ready) held <= in_valid;
      if (fire) begin
        pos <= pos_next; tbeg <= tbeg_next; mode <= mode_next;
        depth <= depth_next; bmatch <= bmatch_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sst_fifo.sv -----
`default_nettype none

module sst_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sst_pkg::sst_push_t  push,
  output logic                     space_ok,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sst_pkg::sst_result_t     head
);
  import sst_pkg::*;

  sst_result_t mem [4];
  logic [1:0]  wptr;
  logic [1:0]  rptr;
  logic [2:0]  count;
  logic        pop;

  assign out_valid = count != 3'd0;
  assign pop       = out_valid && out_ready;
  assign space_ok  = count <= 3'd2;
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wptr] <= push.r0;
    if (push.count == 2'd2) mem[wptr + 2'd1] <= push.r1;
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0;
    end else begin
      wptr  <= wptr + push.count;
      rptr  <= rptr + 2'(pop);
      count <= count + 3'(push.count) - 3'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/shader_source_tokenizer_top.sv -----
// Streaming tokenizer for C-style shader text, one source byte per transaction.
// The input channel carries source_byte with end_of_source; an item with
// end_of_source set closes the text and its byte is ignored. The output channel
// carries one token per transaction: kind, start offset, length and a flag that
// marks the last token produced by a given input item.
// An accepted byte sits in an input register while the scanner updates its
// state and writes zero, one or two tokens into a four-entry result queue;
// a token is offered only after the queue has registered it.
// One byte is accepted every cycle while the queue has room for two tokens,
// so the throughput is one byte per clock as long as the receiver keeps up.
// When the receiver stalls, the queue fills and in_ready falls; nothing is
// lost. An end item flushes the pending token or reports an open block
// comment, then emits an end token, and returns offsets to zero for the next text.
// Reset clears the scanner to the idle state at offset zero and empties the
// queue.
`default_nettype none

module shader_source_tokenizer_top #(
  parameter int OFFSET_BITS = 24,
  parameter int MAX_NEST    = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  source_byte,
  input  wire logic        end_of_source,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       token_kind,
  output logic [23:0]      token_start,
  output logic [23:0]      token_length,
  output logic             last_of_run
);
  import sst_pkg::*;

  sst_push_t   push;
  sst_result_t head;
  logic        space_ok;

  sst_scan #(.OFFSET_BITS(OFFSET_BITS), .MAX_NEST(MAX_NEST)) u_scan (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .source_byte(source_byte), .end_of_source(end_of_source),
    .space_ok(space_ok), .push(push)
  );

  sst_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .space_ok(space_ok),
    .out_valid(out_valid), .out_ready(out_ready), .head(head)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign last_of_run  = head.last;

endmodule

`default_nettype wire

// ----- hw/rtl/sst_checker.sv -----
`default_nettype none

module sst_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [5:0]  token_kind,
  input wire logic [23:0] token_length,
  input wire logic        last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Output transaction dropped before acceptance.");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("Output valid directly after reset.");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == 6'd0 |-> last_of_run && token_length == 24'd0)
    else $error("End token malformed.");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_kind <= 6'd43)
    else $error("Token kind out of range.");

endmodule

bind shader_source_tokenizer_top sst_checker u_sst_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .token_kind(token_kind), .token_length(token_length), .last_of_run(last_of_run)
);

`default_nettype wire
